/* rtl/thash32_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thash32_pkg
// Shared widths, codes and helpers for the 32-bit key tabulation hash.
// ----------------------------------------------------------------------------
package thash32_pkg;

    // Default structure of the tables
    localparam int HALF_BITS_DEF  = 16;
    localparam int ENTRY_BITS_DEF = 16;

    // Fixed payload widths
    localparam int KEY_W    = 32;
    localparam int SEL_W    = 2;
    localparam int INDEX_W  = 17;
    localparam int VALUE_W  = 16;
    localparam int BUCKET_W = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int BB_W       = 5;
    localparam logic [BB_W-1:0] BB_RESET = 5'd16;

    // Register index (paddr word bits)
    localparam logic REG_BUCKET_BITS = 1'b0;

    // Item operation codes
    localparam logic OP_HASH  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Table select codes
    localparam logic [SEL_W-1:0] SEL_HIGH = 2'd0;
    localparam logic [SEL_W-1:0] SEL_LOW  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_SUM  = 2'd2;

    // Low-bit mask for a bucket count of 2^bits; saturates at BUCKET_W bits.
    function automatic logic [BUCKET_W-1:0] bucket_mask(input logic [BB_W-1:0] bits);
        logic [BB_W-1:0]   sat;
        logic [BUCKET_W:0] wide;
        begin
            sat  = (bits > BB_W'(BUCKET_W)) ? BB_W'(BUCKET_W) : bits;
            wide = ~({(BUCKET_W + 1){1'b1}} << sat);
            return wide[BUCKET_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/thash32_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thash32_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module thash32_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

/* rtl/thash32_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thash32_cfg
// APB-style register port holding the bucket_bits register.
// ----------------------------------------------------------------------------
module thash32_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [thash32_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [thash32_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [thash32_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                     pready,
    output logic      [thash32_pkg::BB_W-1:0]        o_bucket_bits
);
    import thash32_pkg::*;

    logic [BB_W-1:0] r_bucket_bits;
    logic [BB_W-1:0] n_bucket_bits;
    logic            wr_bb;

    assign pready = 1'b1;
    assign wr_bb  = psel && penable && pwrite && (paddr[2] == REG_BUCKET_BITS);
    assign n_bucket_bits = wr_bb ? pwdata[BB_W-1:0] : r_bucket_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_bits <= BB_RESET;
        end else begin
            r_bucket_bits <= n_bucket_bits;
        end
    end

    // Read decode; the unused word reads as zero
    always_comb begin
        unique case (paddr[2])
            REG_BUCKET_BITS: prdata = {{(CFG_DATA_W - BB_W){1'b0}}, r_bucket_bits};
            default:         prdata = {CFG_DATA_W{1'b0}};
        endcase
    end

    assign o_bucket_bits = r_bucket_bits;

endmodule
`default_nettype wire

/* rtl/thash32_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thash32_out
// Combine stage: XOR the three table words, mask, and hold the result item.
// ----------------------------------------------------------------------------
module thash32_out #(
    parameter int ENTRY_BITS = thash32_pkg::ENTRY_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load,
    input  wire logic [ENTRY_BITS-1:0]             i_hi_word,
    input  wire logic [ENTRY_BITS-1:0]             i_lo_word,
    input  wire logic [ENTRY_BITS-1:0]             i_sum_word,
    input  wire logic [thash32_pkg::BB_W-1:0]      i_bucket_bits,
    output logic                                   o_load_ready,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [thash32_pkg::BUCKET_W-1:0]  o_bucket
);
    import thash32_pkg::*;

    logic                  r_b_valid;
    logic                  n_b_valid;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [BUCKET_W-1:0]   r_bucket;
    logic [ENTRY_BITS-1:0] mix;
    logic [BUCKET_W-1:0]   mix_ext;
    logic                  out_free;
    logic                  b_go;

    assign mix = i_hi_word ^ i_lo_word ^ i_sum_word;

    generate
        if (ENTRY_BITS >= BUCKET_W) begin : g_trunc
            assign mix_ext = mix[BUCKET_W-1:0];
        end else begin : g_ext
            assign mix_ext = {{(BUCKET_W - ENTRY_BITS){1'b0}}, mix};
        end
    endgenerate

    assign out_free     = !r_out_valid || i_out_ready;
    assign b_go         = r_b_valid && out_free;
    assign o_load_ready = !r_b_valid || b_go;

    always_comb begin
        n_b_valid = r_b_valid;
        if (i_load) begin
            n_b_valid = 1'b1;
        end else if (b_go) begin
            n_b_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (b_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_b_valid   <= n_b_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_bucket <= mix_ext & bucket_mask(i_bucket_bits);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bucket    = r_bucket;

endmodule
`default_nettype wire

/* rtl/tabulation_hash_32bit_key.sv */
// Path: a hash item's result passes the input register (loaded at the
//   accepting edge), then the registered table read and the result
//   register; it is held there while the result side stalls.
// Throughput: one item per cycle while the result side does not stall; each
//   table has one read and one write port, and an item uses at most one of them.
// Reset: control and bucket_bits (to 16) clear on the synchronous reset; the
//   tables are not initialized and must be written before they are hashed.
`default_nettype none
// ----------------------------------------------------------------------------
// tabulation_hash_32bit_key
// Tabulation hash of a 32-bit key into 2^bucket_bits buckets, with table
// words loaded through write items on the same input channel.
// ----------------------------------------------------------------------------
module tabulation_hash_32bit_key #(
    parameter int HALF_BITS  = thash32_pkg::HALF_BITS_DEF,
    parameter int ENTRY_BITS = thash32_pkg::ENTRY_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input item channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_op,
    input  wire logic [thash32_pkg::KEY_W-1:0]       i_key,
    input  wire logic [thash32_pkg::SEL_W-1:0]       i_table_select,
    input  wire logic [thash32_pkg::INDEX_W-1:0]     i_entry_index,
    input  wire logic [thash32_pkg::VALUE_W-1:0]     i_entry_value,
    // Result item channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [thash32_pkg::BUCKET_W-1:0]    o_bucket,
    // Configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [thash32_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [thash32_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [thash32_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                     pready
);
    import thash32_pkg::*;

    localparam int HALF_DEPTH = 1 << HALF_BITS;
    localparam int SUM_DEPTH  = 1 << (HALF_BITS + 1);
    localparam int SUM_BITS   = HALF_BITS + 1;

    // Stage A: input register. Payload holds without reset.
    logic                  r_a_valid;
    logic                  n_a_valid;
    logic                  r_a_op;
    logic [KEY_W-1:0]      r_a_key;
    logic [SEL_W-1:0]      r_a_sel;
    logic [INDEX_W-1:0]    r_a_idx;
    logic [VALUE_W-1:0]    r_a_val;

    logic                  in_take;
    logic                  a_go;
    logic                  b_ready;
    logic                  rd_load;

    logic [HALF_BITS-1:0]  key_hi;
    logic [HALF_BITS-1:0]  key_lo;
    logic [SUM_BITS-1:0]   sum_idx;
    logic [ENTRY_BITS-1:0] wr_word;
    logic                  we_hi;
    logic                  we_lo;
    logic                  we_sum;

    logic [ENTRY_BITS-1:0] hi_word;
    logic [ENTRY_BITS-1:0] lo_word;
    logic [ENTRY_BITS-1:0] sum_word;
    logic [BB_W-1:0]       bucket_bits;

    // A write item retires in stage A; a hash item moves on only when the
    // combine stage can take the table words.
    assign a_go       = r_a_valid && ((r_a_op == OP_WRITE) || b_ready);
    assign o_in_ready = !r_a_valid || a_go;
    assign in_take    = i_in_valid && o_in_ready;
    assign rd_load    = a_go && (r_a_op == OP_HASH);

    always_comb begin
        n_a_valid = r_a_valid;
        if (in_take) begin
            n_a_valid = 1'b1;
        end else if (a_go) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_op  <= i_op;
            r_a_key <= i_key;
            r_a_sel <= i_table_select;
            r_a_idx <= i_entry_index;
            r_a_val <= i_entry_value;
        end
    end

    // Table addresses for a hash: the two halves and their sum, one bit wider
    assign key_hi  = r_a_key[2*HALF_BITS-1:HALF_BITS];
    assign key_lo  = r_a_key[HALF_BITS-1:0];
    assign sum_idx = {1'b0, key_hi} + {1'b0, key_lo};

    // Fit the written word to the table width
    generate
        if (ENTRY_BITS >= VALUE_W) begin : g_val_ext
            assign wr_word = {{(ENTRY_BITS - VALUE_W){1'b0}}, r_a_val};
        end else begin : g_val_trunc
            assign wr_word = r_a_val[ENTRY_BITS-1:0];
        end
    endgenerate

    // Route a write item to its table; the unused select code writes nothing
    always_comb begin
        we_hi  = 1'b0;
        we_lo  = 1'b0;
        we_sum = 1'b0;
        if (a_go && (r_a_op == OP_WRITE)) begin
            unique case (r_a_sel)
                SEL_HIGH: we_hi  = 1'b1;
                SEL_LOW:  we_lo  = 1'b1;
                SEL_SUM:  we_sum = 1'b1;
                default:  we_hi  = 1'b0;
            endcase
        end
    end

    thash32_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (HALF_DEPTH)
    ) u_high_half_table (
        .i_clk     (i_clk),
        .i_wr_en   (we_hi),
        .i_wr_addr (r_a_idx[HALF_BITS-1:0]),
        .i_wr_data (wr_word),
        .i_rd_en   (rd_load),
        .i_rd_addr (key_hi),
        .o_rd_data (hi_word)
    );

    thash32_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (HALF_DEPTH)
    ) u_low_half_table (
        .i_clk     (i_clk),
        .i_wr_en   (we_lo),
        .i_wr_addr (r_a_idx[HALF_BITS-1:0]),
        .i_wr_data (wr_word),
        .i_rd_en   (rd_load),
        .i_rd_addr (key_lo),
        .o_rd_data (lo_word)
    );

    thash32_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (SUM_DEPTH)
    ) u_sum_table (
        .i_clk     (i_clk),
        .i_wr_en   (we_sum),
        .i_wr_addr (r_a_idx[SUM_BITS-1:0]),
        .i_wr_data (wr_word),
        .i_rd_en   (rd_load),
        .i_rd_addr (sum_idx),
        .o_rd_data (sum_word)
    );

    // Stage B and result register: XOR, mask, hold until taken
    thash32_out #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (rd_load),
        .i_hi_word     (hi_word),
        .i_lo_word     (lo_word),
        .i_sum_word    (sum_word),
        .i_bucket_bits (bucket_bits),
        .o_load_ready  (b_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bucket      (o_bucket)
    );

    thash32_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_bucket_bits (bucket_bits)
    );

endmodule
`default_nettype wire

/* rtl/thash32_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// thash32_checker
// Port-level checks on the tabulation hash block, bound to the top level.
// ----------------------------------------------------------------------------
module thash32_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    input  wire logic                                o_in_ready,
    input  wire logic                                i_op,
    input  wire logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    input  wire logic [thash32_pkg::BUCKET_W-1:0]    o_bucket,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [thash32_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [thash32_pkg::CFG_DATA_W-1:0]  pwdata
);
    import thash32_pkg::*;

    logic [BB_W-1:0] r_bits;
    logic [2:0]      r_pending;
    logic            hash_in;
    logic            item_out;

    assign hash_in  = i_in_valid && o_in_ready && (i_op == OP_HASH);
    assign item_out = o_out_valid && i_out_ready;

    // Shadow of bucket_bits and count of hash items still in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits    <= BB_RESET;
            r_pending <= 3'd0;
        end else begin
            if (psel && penable && pwrite && (paddr[2] == REG_BUCKET_BITS)) begin
                r_bits <= pwdata[BB_W-1:0];
            end
            r_pending <= r_pending + 3'(hash_in) - 3'(item_out);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_bucket))
        else $error("result item changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_bucket & ~bucket_mask(r_bits)) == '0))
        else $error("bucket has bits above bucket_bits");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pending != 3'd0))
        else $error("result item without a pending hash item");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd3)
        else $error("more hash items in flight than pipeline stages");

endmodule

bind tabulation_hash_32bit_key thash32_checker u_thash32_checker (.*);
`default_nettype wire

/* bench/tabulation_hash_32bit_key_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tabulation_hash_32bit_key_test
// Self-checking bench for the 32-bit key tabulation hash. A short table of
// directed items loads known table words and hashes the corner keys, then
// phases of random key sequences run under several bucket widths and
// handshake pacings. Every bucket is checked against a booked value, typed
// in or taken from an in-bench model of the three tables.
// ----------------------------------------------------------------------------
module tabulation_hash_32bit_key_test;
    import thash32_pkg::*;

    // Table select code that names no table; such a write is dropped.
    localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

    localparam int HALF_DEPTH    = 1 << HALF_BITS_DEF;
    localparam int SUM_DEPTH     = 2 * HALF_DEPTH;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;     // pipeline is 3 deep; leave margin
    localparam int RANDOM_ITEMS  = 1550;
    localparam int PHASES        = 7;

    typedef enum logic [1:0] {
        PACE_STEADY,
        PACE_SENDER_GAPS,
        PACE_RECEIVER_STALLS,
        PACE_BOTH
    } t_pace;

    // One input item; typed marks a hash whose bucket is written out below.
    typedef struct packed {
        logic                op;
        logic [KEY_W-1:0]    key;
        logic [SEL_W-1:0]    sel;
        logic [INDEX_W-1:0]  idx;
        logic [VALUE_W-1:0]  val;
        logic                typed;
        logic [BUCKET_W-1:0] bucket;
    } t_item;

    // Directed items. Buckets are typed in where they follow from the words
    // loaded just above; the last hash goes through the table model.
    t_item directed_items [0:19] = '{
        // low corner: key 0 reads entry 0 of all three tables
        '{OP_WRITE, 32'h0000_0000, SEL_HIGH, 17'h00000, 16'h1234, 1'b0, 16'h0000},
        '{OP_WRITE, 32'h0000_0000, SEL_LOW,  17'h00000, 16'h00FF, 1'b0, 16'h0000},
        '{OP_WRITE, 32'h0000_0000, SEL_SUM,  17'h00000, 16'hF000, 1'b0, 16'h0000},
        '{OP_HASH,  32'h0000_0000, SEL_HIGH, 17'h00000, 16'h0000, 1'b1, 16'hE2CB},
        // high corner: low-table index wraps from bit 16, sum index is widest
        '{OP_WRITE, 32'h0000_0000, SEL_HIGH, 17'h0FFFF, 16'hFFFF, 1'b0, 16'h0000},
        '{OP_WRITE, 32'h0000_0000, SEL_LOW,  17'h1FFFF, 16'hA5A5, 1'b0, 16'h0000},
        '{OP_WRITE, 32'h0000_0000, SEL_SUM,  17'h1FFFE, 16'h0F0F, 1'b0, 16'h0000},
        '{OP_HASH,  32'hFFFF_FFFF, SEL_HIGH, 17'h00000, 16'h0000, 1'b1, 16'h5555},
        // unused select: must leave every table as it was
        '{OP_WRITE, 32'h0000_0000, SEL_NONE, 17'h00000, 16'hDEAD, 1'b0, 16'h0000},
        '{OP_HASH,  32'h0000_0000, SEL_HIGH, 17'h00000, 16'h0000, 1'b1, 16'hE2CB},
        // one half all ones, the other all zeros
        '{OP_WRITE, 32'h0000_0000, SEL_SUM,  17'h0FFFF, 16'h8001, 1'b0, 16'h0000},
        '{OP_HASH,  32'hFFFF_0000, SEL_HIGH, 17'h00000, 16'h0000, 1'b1, 16'h7F01},
        '{OP_WRITE, 32'h0000_0000, SEL_HIGH, 17'h10000, 16'h0001, 1'b0, 16'h0000},
        '{OP_HASH,  32'h0000_FFFF, SEL_HIGH, 17'h00000, 16'h0000, 1'b1, 16'h25A5},
        // half sum carries into bit 16 of the sum index
        '{OP_WRITE, 32'h0000_0000, SEL_HIGH, 17'h08000, 16'h0000, 1'b0, 16'h0000},
        '{OP_WRITE, 32'h0000_0000, SEL_LOW,  17'h18000, 16'h0000, 1'b0, 16'h0000},
        '{OP_WRITE, 32'h0000_0000, SEL_SUM,  17'h10000, 16'h7777, 1'b0, 16'h0000},
        '{OP_HASH,  32'h8000_8000, SEL_HIGH, 17'h00000, 16'h0000, 1'b1, 16'h7777},
        // overwrite an entry and hash it on the very next item
        '{OP_WRITE, 32'h0000_0000, SEL_LOW,  17'h00000, 16'hBEEF, 1'b0, 16'h0000},
        '{OP_HASH,  32'h0000_0000, SEL_HIGH, 17'h00000, 16'h0000, 1'b0, 16'h0000}
    };

    // Random phases: bucket width and pacing, extremes and saturation first.
    logic [BB_W-1:0] phase_bits [0:PHASES-1] = '{5'd0, 5'd31, 5'd1, 5'd17,
                                                  5'd8, 5'd15, 5'd16};
    t_pace phase_pace [0:PHASES-1] = '{PACE_SENDER_GAPS, PACE_RECEIVER_STALLS,
                                       PACE_BOTH, PACE_STEADY, PACE_SENDER_GAPS,
                                       PACE_RECEIVER_STALLS, PACE_BOTH};

    // Block ports; every input starts at a known value.
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic                  i_op           = OP_HASH;
    logic [KEY_W-1:0]      i_key          = '0;
    logic [SEL_W-1:0]      i_table_select = SEL_HIGH;
    logic [INDEX_W-1:0]    i_entry_index  = '0;
    logic [VALUE_W-1:0]    i_entry_value  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [BUCKET_W-1:0]   o_bucket;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr          = '0;
    logic [CFG_DATA_W-1:0] pwdata         = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Table model: words plus a written flag per entry, so that a hash never
    // lands on an entry that holds no defined word yet.
    logic [ENTRY_BITS_DEF-1:0] high_words [0:HALF_DEPTH-1];
    logic [ENTRY_BITS_DEF-1:0] low_words  [0:HALF_DEPTH-1];
    logic [ENTRY_BITS_DEF-1:0] sum_words  [0:SUM_DEPTH-1];
    bit                        high_loaded [0:HALF_DEPTH-1];
    bit                        low_loaded  [0:HALF_DEPTH-1];
    bit                        sum_loaded  [0:SUM_DEPTH-1];
    logic [BB_W-1:0]           bucket_bits_now = BB_RESET;

    logic [BUCKET_W-1:0] pending_buckets [$];   // buckets still owed, oldest first
    logic [BUCKET_W-1:0] owed_bucket;
    logic [KEY_W-1:0]    recent_keys [$];
    int                  mismatches   = 0;
    int                  loaded_items = 0;       // accepted items that do work
    t_pace               pace         = PACE_STEADY;

    tabulation_hash_32bit_key dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_table_select (i_table_select),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bucket       (o_bucket),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #4 i_clk = ~i_clk;

    // Hard stop in case the block hangs or drops a result.
    initial begin
        #800_000;
        $display("tabulation_hash_32bit_key: mismatch");
        $finish;
    end

    function automatic int sender_gap_pct();
        case (pace)
            PACE_SENDER_GAPS: return 57;
            PACE_BOTH:        return 6;
            default:          return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (pace)
            PACE_RECEIVER_STALLS: return 57;
            PACE_BOTH:            return 6;
            default:              return 0;
        endcase
    endfunction

    // XOR of the three table words, cut to the low bucket_bits bits; widths
    // above the bucket port saturate to the full port.
    function automatic logic [BUCKET_W-1:0] hashed_bucket(input logic [KEY_W-1:0] k);
        logic [HALF_BITS_DEF-1:0] hi;
        logic [HALF_BITS_DEF-1:0] lo;
        logic [HALF_BITS_DEF:0]   sum_idx;
        logic [BB_W-1:0]          keep;
        logic [BUCKET_W-1:0]      mix;
        hi      = k[KEY_W-1:HALF_BITS_DEF];
        lo      = k[HALF_BITS_DEF-1:0];
        sum_idx = {1'b0, hi} + {1'b0, lo};
        mix     = high_words[hi] ^ low_words[lo] ^ sum_words[sum_idx];
        keep    = (bucket_bits_now > BB_W'(BUCKET_W)) ? BB_W'(BUCKET_W) : bucket_bits_now;
        return mix & BUCKET_W'((32'd1 << keep) - 32'd1);
    endfunction

    // Half tables drop index bit 16; the unused select drops the item.
    function automatic void store_word(input logic [SEL_W-1:0] sel,
                                       input logic [INDEX_W-1:0] idx,
                                       input logic [VALUE_W-1:0] val);
        case (sel)
            SEL_HIGH: begin
                high_words[idx[HALF_BITS_DEF-1:0]]  = val;
                high_loaded[idx[HALF_BITS_DEF-1:0]] = 1'b1;
            end
            SEL_LOW: begin
                low_words[idx[HALF_BITS_DEF-1:0]]  = val;
                low_loaded[idx[HALF_BITS_DEF-1:0]] = 1'b1;
            end
            SEL_SUM: begin
                sum_words[idx]  = val;
                sum_loaded[idx] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [BUCKET_W-1:0] got,
                                   input logic [BUCKET_W-1:0] want);
        mismatches++;
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    endtask

    // Offer one item, with random idle cycles ahead of it, and hold it until
    // accepted. At the accepting edge, book its bucket or update the tables.
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < sender_gap_pct()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= it.op;
        i_key          <= it.key;
        i_table_select <= it.sel;
        i_entry_index  <= it.idx;
        i_entry_value  <= it.val;
        do @(posedge i_clk); while (!o_in_ready);
        if (it.op == OP_HASH)
            pending_buckets.push_back(it.typed ? it.bucket : hashed_bucket(it.key));
        else
            store_word(it.sel, it.idx, it.val);
        if (it.op == OP_HASH || it.sel != SEL_NONE)
            loaded_items++;
    endtask

    // Random key on a write so that the block has to ignore it.
    task automatic load_entry(input logic [SEL_W-1:0] sel, input logic [INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] val);
        t_item it;
        it = '{OP_WRITE, KEY_W'($urandom), sel, idx, val, 1'b0, '0};
        send_item(it);
    endtask

    // Random write fields on a hash, likewise ignored.
    task automatic hash_key(input logic [KEY_W-1:0] k);
        t_item it;
        it = '{OP_HASH, k, SEL_W'($urandom_range(3)), INDEX_W'($urandom),
               VALUE_W'($urandom), 1'b0, '0};
        send_item(it);
    endtask

    // Drop valid and wait until every booked bucket has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_buckets.size() != 0);
    endtask

    // APB write of bucket_bits: only while the block is idle.
    task automatic set_bucket_bits(input logic [BB_W-1:0] bits);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BUCKET_BITS, 2'b00};
        pwdata  <= CFG_DATA_W'(bits);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        bucket_bits_now = bits;
    endtask

    // One well-formed sequence: maybe a stray write, then load whatever the
    // chosen key still lacks (sometimes reload it anyway), then hash the key.
    task automatic run_key_sequence();
        logic [KEY_W-1:0]         k;
        logic [HALF_BITS_DEF-1:0] hi;
        logic [HALF_BITS_DEF-1:0] lo;
        logic [HALF_BITS_DEF:0]   sum_idx;
        int                       pick;
        if ($urandom_range(99) < 10)
            load_entry(SEL_W'($urandom_range(3)), INDEX_W'($urandom), VALUE_W'($urandom));
        pick = $urandom_range(99);
        k    = $urandom;
        if (pick >= 55 && pick < 85 && recent_keys.size() != 0) begin
            // revisit a key whose entries may have been rewritten since
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        end else if (pick >= 85) begin
            // pin one half to a corner
            case ($urandom_range(3))
                0: k[KEY_W-1:HALF_BITS_DEF] = '0;
                1: k[KEY_W-1:HALF_BITS_DEF] = '1;
                2: k[HALF_BITS_DEF-1:0]     = '0;
                default: k[HALF_BITS_DEF-1:0] = '1;
            endcase
        end
        hi      = k[KEY_W-1:HALF_BITS_DEF];
        lo      = k[HALF_BITS_DEF-1:0];
        sum_idx = {1'b0, hi} + {1'b0, lo};
        // Half-table indexes carry a random bit 16, which must wrap away.
        if (!high_loaded[hi] || $urandom_range(99) < 15)
            load_entry(SEL_HIGH, {1'($urandom_range(1)), hi}, VALUE_W'($urandom));
        if (!low_loaded[lo] || $urandom_range(99) < 15)
            load_entry(SEL_LOW, {1'($urandom_range(1)), lo}, VALUE_W'($urandom));
        if (!sum_loaded[sum_idx] || $urandom_range(99) < 15)
            load_entry(SEL_SUM, sum_idx, VALUE_W'($urandom));
        hash_key(k);
        recent_keys.push_back(k);
        if (recent_keys.size() > 64)
            void'(recent_keys.pop_front());
    endtask

    // Result side: stall at random per the pacing, and check each accepted
    // bucket against the oldest one booked.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct());
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_buckets.size() == 0) begin
                report_mismatch("bucket with none pending", o_bucket, '0);
            end else begin
                owed_bucket = pending_buckets.pop_front();
                if (o_bucket !== owed_bucket)
                    report_mismatch("bucket", o_bucket, owed_bucket);
            end
        end
    end

    // Main sequence: reset, directed items at the reset width, then the
    // random phases, each behind a fresh bucket_bits write.
    initial begin
        int phase_end;
        int half_way;
        bit paused;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs at full rate on both sides.
        pace = PACE_STEADY;
        foreach (directed_items[i])
            send_item(directed_items[i]);

        for (int p = 0; p < PHASES; p++) begin
            set_bucket_bits(phase_bits[p]);
            pace      = phase_pace[p];
            phase_end = loaded_items + RANDOM_ITEMS / PHASES;
            half_way  = loaded_items + RANDOM_ITEMS / (2 * PHASES);
            paused    = 1'b0;
            while (loaded_items < phase_end) begin
                run_key_sequence();
                // Hold off mid-phase until the pipeline runs dry.
                if (!paused && loaded_items >= half_way) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("tabulation_hash_32bit_key: match");
        else
            $display("tabulation_hash_32bit_key: mismatch");
        $finish;
    end

endmodule
